### rtl/dpm_pkg.sv
`timescale 1ns / 1ps

package dpm_pkg;

    localparam int TICK_W  = 32;
    localparam int MS_W    = 27;
    localparam int CMP_W   = (TICK_W > MS_W) ? TICK_W : MS_W;
    localparam int LIGHT_W = 16;
    localparam int SEC_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    localparam logic [1:0] MODE_DIM    = 2'd0;
    localparam logic [1:0] MODE_BRIGHT = 2'd1;
    localparam logic [1:0] MODE_AUTO   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_UP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_DN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_S   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HV_EXTRA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE      = 3'd5;

    typedef logic [TICK_W-1:0] t_tick;

    typedef struct packed {
        t_tick              now;
        logic               key;
        logic               motion;
        logic               suppressed;
        logic               light_valid;
        logic [LIGHT_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [LIGHT_W-1:0] thresh_up;
        logic [LIGHT_W-1:0] thresh_dn;
        logic               mute;
        logic [MS_W-1:0]    blank_ms;
        logic [MS_W-1:0]    hv_ms;
    } t_cfg;

    typedef struct packed {
        t_tick              last_act;
        logic               started;
        logic               blanked;
        logic               hv_cut;
        logic               bright;
        logic [LIGHT_W-1:0] prev_light;
        logic               ambiance;
    } t_state;

    typedef struct packed {
        logic startle;
        logic ambiance_on;
        logic bright_on;
        logic hv_power_on;
        logic display_show;
    } t_result;

endpackage

### rtl/dpm_core.sv
`timescale 1ns / 1ps

module dpm_core (
    input  dpm_pkg::t_item   i_item,
    input  dpm_pkg::t_cfg    i_cfg,
    input  dpm_pkg::t_state  i_state,
    output dpm_pkg::t_state  o_state,
    output dpm_pkg::t_result o_result
);

    logic                        wake;
    logic                        bright;
    logic [dpm_pkg::LIGHT_W-1:0] prev_light;
    logic                        blanked;
    logic                        hv_cut;
    logic                        ambiance;
    dpm_pkg::t_tick              last_act;
    dpm_pkg::t_tick              idle;
    logic [dpm_pkg::CMP_W-1:0]   idle_x;
    logic [dpm_pkg::CMP_W-1:0]   blank_x;
    logic [dpm_pkg::CMP_W-1:0]   hv_x;

    // brightness
    always_comb begin
        bright     = i_state.bright;
        prev_light = i_state.prev_light;
        unique case (i_cfg.mode)
            dpm_pkg::MODE_DIM:    bright = 1'b0;
            dpm_pkg::MODE_BRIGHT: bright = 1'b1;
            dpm_pkg::MODE_AUTO: begin
                if (i_item.light_valid) begin
                    if (i_item.level > i_cfg.thresh_up && i_item.level > i_state.prev_light
                        && !i_state.bright) begin
                        bright = 1'b1;
                    end else if (i_item.level < i_cfg.thresh_dn
                                 && i_item.level < i_state.prev_light && i_state.bright) begin
                        bright = 1'b0;
                    end
                    prev_light = i_item.level;
                end
            end
            default: ;
        endcase
    end

    // wake and timeouts
    always_comb begin
        wake     = i_item.key || (i_item.motion && !i_item.suppressed);
        last_act = (wake || !i_state.started) ? i_item.now : i_state.last_act;
        blanked  = wake ? 1'b0 : i_state.blanked;
        hv_cut   = wake ? 1'b0 : i_state.hv_cut;
        ambiance = wake ? 1'b1 : i_state.ambiance;
        idle     = i_item.now - last_act;
        idle_x   = dpm_pkg::CMP_W'(idle);
        blank_x  = dpm_pkg::CMP_W'(i_cfg.blank_ms);
        hv_x     = dpm_pkg::CMP_W'(i_cfg.hv_ms);
        if (idle_x >= blank_x && !blanked && i_cfg.blank_ms != '0) begin
            blanked = 1'b1;
            if (i_cfg.mute) begin
                ambiance = 1'b0;
            end
        end
        if (idle_x >= hv_x && !hv_cut && i_cfg.hv_ms != '0) begin
            hv_cut = 1'b1;
            if (i_cfg.mute) begin
                ambiance = 1'b0;
            end
        end
    end

    always_comb begin
        o_state.last_act   = last_act;
        o_state.started    = 1'b1;
        o_state.blanked    = blanked;
        o_state.hv_cut     = hv_cut;
        o_state.bright     = bright;
        o_state.prev_light = prev_light;
        o_state.ambiance   = ambiance;

        o_result.display_show = !blanked;
        o_result.hv_power_on  = !hv_cut;
        o_result.bright_on    = bright;
        o_result.ambiance_on  = ambiance;
        o_result.startle      = wake && (i_state.blanked || i_state.hv_cut);
    end

endmodule

### rtl/display_power_manager.sv
`timescale 1ns / 1ps
// Path from input beat to result beat: input register, then result register.
// Throughput: one tick per cycle while the output is not stalled; the state update fits in the single compute stage.
// Backpressure on the output stalls the compute stage; the input register still
// takes a beat while it is empty.
// Reset (synchronous, active low) clears state and loads register defaults.

module display_power_manager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], key_activity[32], motion_detected[33], motion_suppressed[34],
    // light_valid[35], light_level[51:36], zero pad[55:52]
    input  logic [dpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // display_show[0], hv_power_on[1], bright_on[2], ambiance_on[3],
    // startle_pulse[4], zero pad[7:5]
    output logic [dpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic [1:0]                   r_mode;
    logic [dpm_pkg::LIGHT_W-1:0]  r_thresh_up;
    logic [dpm_pkg::LIGHT_W-1:0]  r_thresh_dn;
    logic [dpm_pkg::SEC_W-1:0]    r_blank_s;
    logic [dpm_pkg::SEC_W-1:0]    r_hv_extra_s;
    logic                         r_mute;
    logic [dpm_pkg::MS_W-1:0]     r_blank_ms;
    logic [dpm_pkg::MS_W-1:0]     r_hv_ms;

    logic                         r_in_valid;
    dpm_pkg::t_item               r_in;
    logic                         r_out_valid;
    dpm_pkg::t_result             r_out;
    dpm_pkg::t_state              r_state;

    dpm_pkg::t_item               n_in;
    dpm_pkg::t_cfg                cfg;
    dpm_pkg::t_state              n_state;
    dpm_pkg::t_result             n_out;
    logic                         out_free;
    logic                         fire;
    logic                         in_take;
    logic [dpm_pkg::SEC_W:0]      total_s;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign n_in.now         = dpm_pkg::TICK_W'(s_axis_tdata[31:0]);
    assign n_in.key         = s_axis_tdata[32];
    assign n_in.motion      = s_axis_tdata[33];
    assign n_in.suppressed  = s_axis_tdata[34];
    assign n_in.light_valid = s_axis_tdata[35];
    assign n_in.level       = s_axis_tdata[51:36];

    assign cfg.mode      = r_mode;
    assign cfg.thresh_up = r_thresh_up;
    assign cfg.thresh_dn = r_thresh_dn;
    assign cfg.mute      = r_mute;
    assign cfg.blank_ms  = r_blank_ms;
    assign cfg.hv_ms     = r_hv_ms;

    assign total_s = {1'b0, r_blank_s} + {1'b0, r_hv_extra_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= dpm_pkg::MODE_AUTO;
            r_thresh_up  <= '0;
            r_thresh_dn  <= '0;
            r_blank_s    <= '0;
            r_hv_extra_s <= '0;
            r_mute       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpm_pkg::REG_MODE:      r_mode       <= i_cfg_data[1:0];
                dpm_pkg::REG_THRESH_UP: r_thresh_up  <= i_cfg_data;
                dpm_pkg::REG_THRESH_DN: r_thresh_dn  <= i_cfg_data;
                dpm_pkg::REG_BLANK_S:   r_blank_s    <= i_cfg_data;
                dpm_pkg::REG_HV_EXTRA:  r_hv_extra_s <= i_cfg_data;
                dpm_pkg::REG_MUTE:      r_mute       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // millisecond thresholds, refreshed every cycle from the second counts
    always_ff @(posedge i_clk) begin
        r_blank_ms <= dpm_pkg::MS_W'(r_blank_s) * dpm_pkg::MS_W'(dpm_pkg::MS_PER_S);
        r_hv_ms    <= dpm_pkg::MS_W'(total_s) * dpm_pkg::MS_W'(dpm_pkg::MS_PER_S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= n_in;
        end
    end

    dpm_core u_core (
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_act   <= '0;
            r_state.started    <= 1'b0;
            r_state.blanked    <= 1'b0;
            r_state.hv_cut     <= 1'b0;
            r_state.bright     <= 1'b1;
            r_state.prev_light <= '0;
            r_state.ambiance   <= 1'b1;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dpm_pkg::OUT_DATA_W'(r_out);

    a_startle_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.startle |-> r_out.display_show && r_out.hv_power_on)
        else $error("startle with display or hv still off");

    a_fixed_dim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == dpm_pkg::MODE_DIM |=> !r_state.bright)
        else $error("fixed dim mode left bright on");

    a_fixed_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == dpm_pkg::MODE_BRIGHT |=> r_state.bright)
        else $error("fixed bright mode left dim");

    a_wake_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.key |=> r_state.last_act == $past(r_in.now) && r_state.ambiance)
        else $error("key beat did not restart idle timer");

endmodule
